>>> hw/rtl/dig_pkg.sv
// Shared types, constants and helper functions for the diagonal interleaver.
package dig_pkg;

  localparam int MAX_ROWS          = 12;
  localparam int MAX_CW_BITS       = 8;
  localparam int CW_W              = 8;
  localparam int SYM_W             = 12;
  localparam int CFG_W             = 4;
  localparam int ROW_IDX_W         = $clog2(MAX_ROWS);
  localparam int BIT_IDX_W         = $clog2(MAX_CW_BITS);

  localparam logic [CFG_W-1:0] MIN_ROWS_V    = CFG_W'(5);
  localparam logic [CFG_W-1:0] MAX_ROWS_V    = CFG_W'(MAX_ROWS);
  localparam logic [CFG_W-1:0] MIN_BITS_V    = CFG_W'(5);
  localparam logic [CFG_W-1:0] MAX_BITS_V    = CFG_W'(MAX_CW_BITS);
  localparam logic [CFG_W-1:0] RESET_ROWS    = CFG_W'(10);
  localparam logic [CFG_W-1:0] RESET_BITS    = CFG_W'(8);

  localparam logic REG_ROWS_USED     = 1'b0;
  localparam logic REG_CODEWORD_BITS = 1'b1;

  typedef struct packed {
    logic                 shift_in;
    logic                 emit;
    logic [BIT_IDX_W-1:0] bit_idx;
    logic                 last;
  } dig_cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] rows_eff;
    logic [CFG_W-1:0] bits_eff;
    logic             out_valid;
  } dig_status_t;

  function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] lo,
                                                 input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

  function automatic logic [SYM_W-1:0] gray_to_bin(input logic [SYM_W-1:0] g);
    logic [SYM_W-1:0] acc;
    acc = g;
    acc = acc ^ (acc >> 1);
    acc = acc ^ (acc >> 2);
    acc = acc ^ (acc >> 4);
    acc = acc ^ (acc >> 8);
    return acc;
  endfunction

endpackage

>>> hw/rtl/diagonal_interleave_gray_decode.sv
// Top level: diagonal bit interleaver with Gray decoding of each symbol.
//
// Input channel (in_valid/in_ready/codeword): one codeword per transaction.
// A block is rows_used codewords (clamped to 5..12); codeword_bits (clamped
// to 5..8) gives the used width and the number of symbols per block.
// Output channel (out_valid/out_ready): one symbol per transaction with its
// Gray-decoded value; last marks the final symbol of a block.
// Codewords load one per cycle into a shift line. After the final codeword
// the block stops taking input and emits codeword_bits symbols, one per
// cycle while the output register can take them, by rotating the line; the
// first symbol is registered from the emit state that the final codeword
// enters. The output register decouples the two sides: input reopens
// as soon as the last symbol is registered. A stalled receiver holds the
// output register and pauses the rotation.
// Reset restores rows_used=10, codeword_bits=8 and an empty block; any
// configuration write also drops a partly loaded block or one being emitted.
module diagonal_interleave_gray_decode (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [dig_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dig_pkg::CW_W-1:0]      codeword,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dig_pkg::SYM_W-1:0]     gray_symbol,
  output logic [dig_pkg::SYM_W-1:0]     raw_symbol,
  output logic                          last
);

  dig_pkg::dig_cmd_t    cmd;
  dig_pkg::dig_status_t status;

  dig_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  dig_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .codeword    (codeword),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .gray_symbol (gray_symbol),
    .raw_symbol  (raw_symbol),
    .last        (last)
  );

endmodule

>>> hw/rtl/dig_datapath.sv
// Datapath: config registers, codeword shift/rotate line and output register.
module dig_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [dig_pkg::CFG_W-1:0]     cfg_data,
  input  logic [dig_pkg::CW_W-1:0]      codeword,
  input  logic                          out_ready,
  input  dig_pkg::dig_cmd_t             cmd,
  output dig_pkg::dig_status_t          status,
  output logic                          out_valid,
  output logic [dig_pkg::SYM_W-1:0]     gray_symbol,
  output logic [dig_pkg::SYM_W-1:0]     raw_symbol,
  output logic                          last
);

  logic [dig_pkg::CFG_W-1:0]     rows_used;
  logic [dig_pkg::CFG_W-1:0]     codeword_bits;
  logic [dig_pkg::CFG_W-1:0]     rows_eff;
  logic [dig_pkg::CW_W-1:0]      row_reg [dig_pkg::MAX_ROWS];
  logic [dig_pkg::CW_W-1:0]      head_next;
  logic [dig_pkg::ROW_IDX_W-1:0] tail_idx;
  logic [dig_pkg::SYM_W-1:0]     column;
  logic [dig_pkg::SYM_W-1:0]     sym;
  logic [dig_pkg::CFG_W-1:0]     shift_amt;

  assign rows_eff = dig_pkg::clamp_cfg(rows_used, dig_pkg::MIN_ROWS_V, dig_pkg::MAX_ROWS_V);

  assign status.rows_eff  = rows_eff;
  assign status.bits_eff  = dig_pkg::clamp_cfg(codeword_bits, dig_pkg::MIN_BITS_V,
                                               dig_pkg::MAX_BITS_V);
  assign status.out_valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used     <= dig_pkg::RESET_ROWS;
      codeword_bits <= dig_pkg::RESET_BITS;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        dig_pkg::REG_ROWS_USED:     rows_used     <= cfg_data;
        dig_pkg::REG_CODEWORD_BITS: codeword_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  // Entry m holds codeword (i-1-m) mod rows while symbol i is built.
  assign tail_idx  = dig_pkg::ROW_IDX_W'(rows_eff - dig_pkg::CFG_W'(1));
  assign head_next = cmd.shift_in ? codeword : row_reg[tail_idx];

  always_ff @(posedge clk) begin
    if (cmd.shift_in || cmd.emit) begin
      row_reg[0] <= head_next;
      for (int m = 1; m < dig_pkg::MAX_ROWS; m++) begin
        row_reg[m] <= row_reg[m-1];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < dig_pkg::MAX_ROWS; j++) begin
      column[dig_pkg::SYM_W-1-j] = row_reg[j][cmd.bit_idx];
    end
  end

  assign shift_amt = dig_pkg::CFG_W'(dig_pkg::MAX_ROWS) - rows_eff;
  assign sym       = column >> shift_amt;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      gray_symbol <= sym;
      raw_symbol  <= dig_pkg::gray_to_bin(sym);
      last        <= cmd.last;
    end
  end

endmodule

>>> hw/rtl/dig_ctrl.sv
// Controller: load counter, symbol counter and load/emit state machine.
module dig_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic                 in_valid,
  input  logic                 out_ready,
  input  dig_pkg::dig_status_t status,
  output logic                 in_ready,
  output dig_pkg::dig_cmd_t    cmd
);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                          state;
  logic                          state_next;
  logic [dig_pkg::CFG_W-1:0]     count;
  logic [dig_pkg::CFG_W-1:0]     count_next;
  logic [dig_pkg::BIT_IDX_W-1:0] bit_idx;
  logic [dig_pkg::BIT_IDX_W-1:0] bit_idx_next;
  logic                          in_take;
  logic                          emit;

  assign in_ready = (state == ST_LOAD);
  assign in_take  = in_valid && in_ready;
  assign emit     = (state == ST_EMIT) && (!status.out_valid || out_ready);

  assign cmd.shift_in = in_take;
  assign cmd.emit     = emit;
  assign cmd.bit_idx  = bit_idx;
  assign cmd.last     = (bit_idx == '0);

  always_comb begin
    state_next   = state;
    count_next   = count;
    bit_idx_next = bit_idx;
    unique case (state)
      ST_LOAD: begin
        if (in_take) begin
          if (count + dig_pkg::CFG_W'(1) == status.rows_eff) begin
            state_next   = ST_EMIT;
            count_next   = '0;
            bit_idx_next = dig_pkg::BIT_IDX_W'(status.bits_eff - dig_pkg::CFG_W'(1));
          end else begin
            count_next = count + dig_pkg::CFG_W'(1);
          end
        end
      end
      ST_EMIT: begin
        if (emit) begin
          if (bit_idx == '0) begin
            state_next = ST_LOAD;
          end else begin
            bit_idx_next = bit_idx - dig_pkg::BIT_IDX_W'(1);
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
    if (cfg_wr_en) begin
      state_next = ST_LOAD;
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      bit_idx <= '0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      bit_idx <= bit_idx_next;
    end
  end

endmodule

>>> verif/diagonal_interleave_gray_decode_chk.sv
// Checker: predicts every interleaved symbol and compares it with the block's output.
module diagonal_interleave_gray_decode_chk (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [dig_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [dig_pkg::CW_W-1:0]  codeword,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [dig_pkg::SYM_W-1:0] gray_symbol,
  input  logic [dig_pkg::SYM_W-1:0] raw_symbol,
  input  logic                      last,
  output int                        errors,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [dig_pkg::SYM_W-1:0] gray;
    logic [dig_pkg::SYM_W-1:0] raw;
    logic                      last;
  } symbol_t;

  symbol_t                   symbol_q[$];
  logic [dig_pkg::CFG_W-1:0] rows_setting;
  logic [dig_pkg::CFG_W-1:0] bits_setting;
  logic [dig_pkg::CW_W-1:0]  rows_held[dig_pkg::MAX_ROWS];
  int unsigned               held;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic int unsigned clamp_setting(input logic [dig_pkg::CFG_W-1:0] v,
                                                input logic [dig_pkg::CFG_W-1:0] lo,
                                                input logic [dig_pkg::CFG_W-1:0] hi);
    if (v < lo) return 32'(lo);
    if (v > hi) return 32'(hi);
    return 32'(v);
  endfunction

  function automatic logic [dig_pkg::SYM_W-1:0] binary_of_gray(
    input logic [dig_pkg::SYM_W-1:0] g);
    logic [dig_pkg::SYM_W-1:0] b;
    b[dig_pkg::SYM_W-1] = g[dig_pkg::SYM_W-1];
    for (int k = dig_pkg::SYM_W - 2; k >= 0; k--) b[k] = b[k+1] ^ g[k];
    return b;
  endfunction

  task automatic take_codeword(input logic [dig_pkg::CW_W-1:0] cw);
    int unsigned nrows;
    int unsigned nbits;
    int unsigned row;
    symbol_t     s;
    nrows = clamp_setting(rows_setting, dig_pkg::MIN_ROWS_V, dig_pkg::MAX_ROWS_V);
    nbits = clamp_setting(bits_setting, dig_pkg::MIN_BITS_V, dig_pkg::MAX_BITS_V);
    if (held >= nrows) held = 0;
    rows_held[held] = cw;
    held++;
    if (held == nrows) begin
      for (int unsigned i = 0; i < nbits; i++) begin
        s = '0;
        for (int unsigned j = 0; j < nrows; j++) begin
          // diagonal walk, wraps around the block
          row = (i + 2 * nrows - j - 1) % nrows;
          s.gray[nrows-1-j] = rows_held[row][nbits-1-i];
        end
        s.raw  = binary_of_gray(s.gray);
        s.last = (i + 1 == nbits);
        symbol_q.push_back(s);
      end
      held = 0;
    end
  endtask

  always @(posedge clk) begin
    int      nerr;
    symbol_t want;
    nerr = 0;
    if (rst) begin
      rows_setting = dig_pkg::RESET_ROWS;
      bits_setting = dig_pkg::RESET_BITS;
      held         = 0;
      symbol_q.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == dig_pkg::REG_ROWS_USED) rows_setting = cfg_data;
        else bits_setting = cfg_data;
        held = 0;
      end
      if (in_valid && in_ready) take_codeword(codeword);
      if (out_valid && out_ready) begin
        if (symbol_q.size() == 0) begin
          $error("unexpected symbol transaction: gray_symbol %03h", gray_symbol);
          nerr++;
        end else begin
          want = symbol_q.pop_front();
          if (gray_symbol !== want.gray) begin
            $error("gray_symbol: expected %03h, actual %03h", want.gray, gray_symbol);
            nerr++;
          end
          if (raw_symbol !== want.raw) begin
            $error("raw_symbol: expected %03h, actual %03h", want.raw, raw_symbol);
            nerr++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, last);
            nerr++;
          end
        end
      end
    end
    errors  <= errors + nerr;
    pending <= symbol_q.size();
  end

endmodule

>>> verif/diagonal_interleave_gray_decode_tb.sv
// Testbench top: drives codewords and register writes, then gives the verdict.
module diagonal_interleave_gray_decode_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE = 12;
  localparam int LIMIT  = 1_000_000;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         cfg_wr_en = 1'b0;
  logic                         cfg_index = 1'b0;
  logic [dig_pkg::CFG_W-1:0]    cfg_data  = '0;
  logic                         in_valid  = 1'b0;
  logic [dig_pkg::CW_W-1:0]     codeword  = '0;
  logic                         out_ready = 1'b0;
  logic                         in_ready;
  logic                         out_valid;
  logic [dig_pkg::SYM_W-1:0]    gray_symbol;
  logic [dig_pkg::SYM_W-1:0]    raw_symbol;
  logic                         last;
  int                           errors;
  int                           pending;
  int                           cycles = 0;
  bit                           calm   = 1'b0;

  diagonal_interleave_gray_decode dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .codeword    (codeword),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .gray_symbol (gray_symbol),
    .raw_symbol  (raw_symbol),
    .last        (last)
  );

  diagonal_interleave_gray_decode_chk chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .codeword    (codeword),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .gray_symbol (gray_symbol),
    .raw_symbol  (raw_symbol),
    .last        (last),
    .errors      (errors),
    .pending     (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("diagonal_interleave_gray_decode_tb: errors");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stalls
  initial begin
    int g;
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      g = pick_gap();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  task automatic send_codeword(input logic [dig_pkg::CW_W-1:0] cw);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    codeword <= cw;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [dig_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [dig_pkg::CW_W-1:0] random_codeword();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return dig_pkg::CW_W'($urandom);
  endfunction

  initial begin
    logic [dig_pkg::CFG_W-1:0] rows_pick[4] = '{4'd5, 4'd12, 4'd15, 4'd12};
    logic [dig_pkg::CFG_W-1:0] bits_pick[4] = '{4'd5, 4'd8, 4'd0, 4'd15};
    logic [dig_pkg::CFG_W-1:0] rv;
    logic [dig_pkg::CFG_W-1:0] bv;
    int                        n;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default block: 10 rows of 8 bits
    send_codeword(8'h00); send_codeword(8'hFF); send_codeword(8'h80);
    send_codeword(8'h01); send_codeword(8'hAA); send_codeword(8'h55);
    send_codeword(8'hFF); send_codeword(8'h00); send_codeword(8'h7F);
    send_codeword(8'hFE);
    drain();
    // below-range settings clamp to the minimum; this block stays partial
    write_reg(dig_pkg::REG_ROWS_USED, 4'd0);
    write_reg(dig_pkg::REG_CODEWORD_BITS, 4'd2);
    send_codeword(8'hFF);
    send_codeword(8'h1F);
    drain();
    // write drops the partial block; above-range width clamps to 8
    write_reg(dig_pkg::REG_CODEWORD_BITS, 4'd15);
    send_codeword(8'hFF); send_codeword(8'h00); send_codeword(8'hE0);
    send_codeword(8'h1F); send_codeword(8'hC3);

    for (int p = 0; p < 10; p++) begin
      drain();
      rv   = (p < 4) ? rows_pick[p] : dig_pkg::CFG_W'($urandom_range(0, 15));
      bv   = (p < 4) ? bits_pick[p] : dig_pkg::CFG_W'($urandom_range(0, 15));
      calm = (p == 5);
      if ($urandom_range(0, 1)) begin
        write_reg(dig_pkg::REG_ROWS_USED, rv);
        write_reg(dig_pkg::REG_CODEWORD_BITS, bv);
      end else begin
        write_reg(dig_pkg::REG_CODEWORD_BITS, bv);
        write_reg(dig_pkg::REG_ROWS_USED, rv);
      end
      n = $urandom_range(30, 50);
      for (int k = 0; k < n; k++) begin
        send_codeword(random_codeword());
        if ($urandom_range(0, 49) == 0) drain();
      end
    end
    calm = 1'b0;

    drain();
    if (errors == 0) $display("diagonal_interleave_gray_decode_tb: clean");
    else $display("diagonal_interleave_gray_decode_tb: errors");
    $finish;
  end

endmodule

>>> diagonal_interleave_gray_decode.f
hw/rtl/dig_pkg.sv
hw/rtl/dig_datapath.sv
hw/rtl/dig_ctrl.sv
hw/rtl/diagonal_interleave_gray_decode.sv
verif/diagonal_interleave_gray_decode_chk.sv
verif/diagonal_interleave_gray_decode_tb.sv
